// ===== hw/rtl/fsla_pkg.sv =====
// fsla_pkg: shared constants, state enum and controller/datapath interface structs
// for the fixed-slot free-list allocator; no dependencies
`default_nettype none

package fsla_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = 10;
  localparam int LINK_W    = 11;
  localparam int CFG_W     = 13;
  localparam int UNIT_W    = 11;
  localparam int PROD_W    = SLOT_W + UNIT_W;
  localparam int OFF_W     = 22;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(SLOTS);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic push;
    logic pop_start;
    logic take_bump;
    logic refuse;
    logic load_head;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_free;
    logic head_empty;
    logic bump_left;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_slot_free_list_allocator_top.sv =====
// fixed_slot_free_list_allocator_top: a free updates the free list when it is accepted; an
// alloc reads the link memory (registered) when it takes from the free list, then does a
// registered multiply before its beat is in the output register; the next item is accepted
// once the beat is registered. Throughput: one free per cycle while no alloc is in progress.
// Reset (synchronous): empty free list, bump counter 0, slot size 8; link memory not cleared.
`default_nettype none

module fixed_slot_free_list_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [12:0] cfg_wdata,   // slot_bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,     // slot_in[9:0], zero fill
  input  wire logic        s_tuser,     // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,     // slot_out[9:0], byte_offset[31:10]
  output logic             m_tuser      // granted
);
  import fsla_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fsla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fsla_ctrl.sv =====
// fsla_ctrl: sequencing state machine for the allocator
// depends on fsla_pkg; drives commands to fsla_dp
`default_nettype none

module fsla_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire fsla_pkg::stat_t stat,
  output fsla_pkg::cmd_t      cmd
);
  import fsla_pkg::*;

  state_t state;
  state_t state_next;
  logic   fire;

  assign s_tready = (state == ST_IDLE);
  assign fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fire && !stat.in_free) begin
          state_next = stat.head_empty ? ST_MUL : ST_POP;
        end
      end
      ST_POP: state_next = ST_MUL;
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.push      = fire && stat.in_free;
        cmd.pop_start = fire && !stat.in_free && !stat.head_empty;
        cmd.take_bump = fire && !stat.in_free && stat.head_empty && stat.bump_left;
        cmd.refuse    = fire && !stat.in_free && stat.head_empty && !stat.bump_left;
      end
      ST_POP:  cmd.load_head = 1'b1;
      ST_MUL:  cmd.mul = 1'b1;
      ST_OUT:  cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fsla_dp.sv =====
// fsla_dp: allocator datapath with link memory, list head, bump counter,
// slot-size register, offset multiplier and output register; depends on fsla_pkg
`default_nettype none

module fsla_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [fsla_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic [fsla_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [fsla_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,
  input  wire fsla_pkg::cmd_t                cmd,
  output fsla_pkg::stat_t                    stat
);
  import fsla_pkg::*;

  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] rd_data;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] bump;
  logic [UNIT_W-1:0] units;
  logic [CFG_W:0]    cfg_sum;
  logic [UNIT_W-1:0] units_next;
  logic [SLOT_W-1:0] slot_in;
  logic [SLOT_W-1:0] res_slot;
  logic              res_granted;
  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] out_slot;
  logic [OFF_W-1:0]  out_off;
  logic              out_granted;

  assign slot_in = s_tdata[SLOT_W-1:0];

  assign stat.in_free    = (s_tuser == FUNC_FREE);
  assign stat.head_empty = (head >= LIST_END);
  assign stat.bump_left  = (bump < LIST_END);
  assign stat.out_free   = !m_tvalid || m_tready;

  // round up to a multiple of 8 bytes, minimum one unit of 8 bytes
  assign cfg_sum    = {1'b0, cfg_wdata} + (CFG_W + 1)'(7);
  assign units_next = (cfg_sum[CFG_W:3] == '0) ? UNIT_W'(1) : cfg_sum[CFG_W:3];

  always_ff @(posedge clk) begin
    if (cmd.push && ({1'b0, slot_in} < LIST_END)) begin
      link_mem[slot_in] <= head;
    end
    if (cmd.pop_start) begin
      rd_data <= link_mem[head[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= LIST_END;
      bump  <= '0;
      units <= UNIT_W'(1);
    end else begin
      if (cfg_wen) begin
        units <= units_next;
      end
      if (cmd.push && ({1'b0, slot_in} < LIST_END)) begin
        head <= {1'b0, slot_in};
      end else if (cmd.load_head) begin
        head <= rd_data;
      end
      if (cmd.take_bump) begin
        bump <= bump + LINK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      res_slot    <= head[SLOT_W-1:0];
      res_granted <= 1'b1;
    end else if (cmd.take_bump) begin
      res_slot    <= bump[SLOT_W-1:0];
      res_granted <= 1'b1;
    end else if (cmd.refuse) begin
      res_slot    <= '0;
      res_granted <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(res_slot) * PROD_W'(units);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slot    <= res_slot;
      out_off     <= {prod[OFF_W-4:0], 3'b000};
      out_granted <= res_granted;
    end
  end

  assign m_tdata = {out_off, out_slot};
  assign m_tuser = out_granted;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: stream-level bench for the fixed-slot free-list allocator; predicts every grant
// from a local copy of the free list, bump counter and slot size and checks each result beat
// depends on fsla_pkg and fixed_slot_free_list_allocator_top
`timescale 1ns / 1ps

module tb_top;
  import fsla_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // local model of the allocator
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] free_head = LIST_END;
  logic [LINK_W-1:0] bump_count = '0;
  logic [13:0]       slot_size = 14'd8;

  grant_t            pending_grants [$];
  logic [SLOT_W-1:0] owned_slots [$];

  bit gaps_on = 1'b1;
  int rx_hold_left = 0;
  int errors = 0;
  int cycle_count = 0;

  fixed_slot_free_list_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // slot_in[9:0], zero fill
    .s_tuser   (s_tuser),    // func
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // slot_out[9:0], byte_offset[31:10]
    .m_tuser   (m_tuser)     // granted
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [13:0] round_slot_size(input logic [CFG_W-1:0] v);
    logic [13:0] s;
    s = ({1'b0, v} + 14'd7) & ~14'd7;
    if (s < 14'd8) s = 14'd8;
    return s;
  endfunction

  task automatic predict_beat(input logic func, input logic [SLOT_W-1:0] slot);
    grant_t g;
    logic [23:0] prod;
    if (func == FUNC_FREE) begin
      link_mem[slot] = free_head;
      free_head = LINK_W'(slot);
    end else begin
      g.granted = 1'b0;
      g.slot = '0;
      g.offset = '0;
      if (free_head != LIST_END) begin
        g.slot = free_head[SLOT_W-1:0];
        free_head = link_mem[g.slot];
        g.granted = 1'b1;
      end else if (bump_count < SLOTS) begin
        g.slot = bump_count[SLOT_W-1:0];
        bump_count = bump_count + 1'b1;
        g.granted = 1'b1;
      end
      if (g.granted) begin
        prod = 24'(g.slot) * 24'(slot_size);
        g.offset = prod[OFF_W-1:0];
        owned_slots.push_back(g.slot);
      end
      pending_grants.push_back(g);
    end
  endtask

  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot);
    if (gaps_on) begin
      while ($urandom_range(99) < 27) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {{(IN_DATA_W-SLOT_W){1'b0}}, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_beat(func, slot);
  endtask

  task automatic send_alloc();
    send_item(FUNC_ALLOC, SLOT_W'($urandom_range(SLOTS-1)));
  endtask

  task automatic free_owned(input int idx);
    logic [SLOT_W-1:0] slot;
    slot = owned_slots[idx];
    owned_slots.delete(idx);
    send_item(FUNC_FREE, slot);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_slot_size(input logic [CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    slot_size = round_slot_size(v);
  endtask

  // bump allocation, lifo reuse and an emptied free list
  task automatic test_basic_alloc_free();
    gaps_on = 1'b1;
    repeat (4) send_alloc();
    free_owned(1);
    free_owned(0);
    repeat (3) send_alloc();
    while (owned_slots.size() != 0) free_owned(0);
    repeat (2) send_alloc();
  endtask

  // receiver holds off at the start while allocs keep coming
  task automatic test_receiver_hold();
    gaps_on = 1'b1;
    rx_hold_left = HOLD_CYCLES;
    repeat (60) send_alloc();
  endtask

  // well-formed traffic: frees of slots held, allocs of any kind
  task automatic test_random_traffic(input int n, input bit with_gaps);
    gaps_on = with_gaps;
    repeat (n) begin
      if (owned_slots.size() != 0 && $urandom_range(99) < 50)
        free_owned($urandom_range(owned_slots.size() - 1));
      else
        send_alloc();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_slot_sizes();
    logic [CFG_W-1:0] sizes [10];
    sizes = '{13'd0, 13'd1, 13'd7, 13'd8, 13'd9, 13'd4095, 13'd4096, 13'd8191, 13'd8184, 13'd0};
    sizes[9] = CFG_W'($urandom_range(8191));
    foreach (sizes[i]) begin
      set_slot_size(sizes[i]);
      test_random_traffic(12, 1'b1);
    end
  endtask

  task automatic test_pause_for_drain();
    test_random_traffic(20, 1'b1);
    drain_results();
    test_random_traffic(20, 1'b1);
  endtask

  // double frees and frees of slots never handed out
  task automatic test_unchecked_frees();
    int pick;
    set_slot_size(CFG_W'($urandom_range(8191)));
    gaps_on = 1'b1;
    repeat (100) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_alloc();
      else if (pick < 70)
        send_item(FUNC_FREE, SLOT_W'($urandom_range(SLOTS-1)));
      else if (owned_slots.size() == 0)
        send_alloc();
      else if (pick < 90)
        free_owned($urandom_range(owned_slots.size() - 1));
      else
        send_item(FUNC_FREE, owned_slots[$]);
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(99) < 27) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_beats
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: tdata %h tuser %b", m_tdata, m_tuser);
      end else begin
        want = pending_grants.pop_front();
        check_field("granted", want.granted, m_tuser);
        check_field("slot_out", want.slot, m_tdata[SLOT_W-1:0]);
        check_field("byte_offset", want.offset, m_tdata[SLOT_W +: OFF_W]);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_alloc_free();
    test_receiver_hold();
    test_slot_sizes();
    test_random_traffic(180, 1'b1);
    test_random_traffic(150, 1'b0);
    test_pause_for_drain();
    test_unchecked_frees();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_grants.size() != 0) errors++;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
